### rtl/core/psgt_pkg.sv
`default_nettype none

package psgt_pkg;

	// Number of tracked streams; valid ids are 1 to NUM_STREAMS.
	localparam int NUM_STREAMS = 8;
	localparam int STREAM_IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam logic [7:0] STREAM_ID_MAX = 8'(NUM_STREAMS);

	// Configuration register map.
	localparam int PADDR_W = 3;
	localparam logic REG_GAP_LIMIT = 1'b0;
	localparam logic [15:0] GAP_LIMIT_RESET = 16'd500;

	// Result classification of one packet header.
	typedef enum logic [1:0] {
		OUTCOME_IGNORED    = 2'd0,
		OUTCOME_FIRST      = 2'd1,
		OUTCOME_ACCEPTED   = 2'd2,
		OUTCOME_FALSE_SYNC = 2'd3
	} outcome_t;

	// Input beat: one received packet header.
	typedef struct packed {
		logic [7:0]  stream_id;
		logic [15:0] sequence_number;
	} item_t;

	// Output beat: classification and the stream's counters after the packet.
	typedef struct packed {
		outcome_t    outcome;
		logic [15:0] gap;
		logic [31:0] received_total;
		logic [31:0] lost_total;
		logic [31:0] false_sync_total;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/per_stream_sequence_gap_tracker.sv
// Per-stream sequence gap tracker.
// The item channel (item_valid, item_ready, item) carries packet headers: a
// stream id and a 16-bit sequence number. The result channel (result_valid,
// result_ready, result) returns exactly one beat per header, in order, with
// the outcome, the wrapping gap and that stream's three 32-bit counters.
// A header is captured in an input register; when the output register is
// free or being emptied, the stream table is read and updated and the
// result is written to the output register. Throughput is one header per
// cycle while results are taken: the table update is a single register
// write per beat, and the next header sees the updated entry directly.
// When the receiver stalls, the result holds and the input register keeps
// one more header; item_ready drops only while both are full.
// Reset clears every stream entry and both valid flags and sets gap_limit to
// 500. gap_limit is written through the APB port at byte address 0.
`default_nettype none

module per_stream_sequence_gap_tracker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire psgt_pkg::item_t              item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output psgt_pkg::result_t                 result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [psgt_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	logic              valid_s1;
	psgt_pkg::item_t   item_s1;
	logic              advance;
	logic [15:0]       gap_limit;
	psgt_pkg::result_t result_d;

	psgt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.gap_limit (gap_limit)
	);

	// Move the held header into the output register when that slot frees up.
	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	psgt_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (advance),
		.item_s1   (item_s1),
		.gap_limit (gap_limit),
		.result_d  (result_d)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= result_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/psgt_cfg.sv
`default_nettype none

module psgt_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [psgt_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output logic      [15:0]                  gap_limit
);

	logic reg_sel;
	logic wr_en;

	// Register index is the word address; byte lanes are ignored.
	assign reg_sel = paddr[psgt_pkg::PADDR_W-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Gap limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit <= psgt_pkg::GAP_LIMIT_RESET;
		end else if (wr_en && (reg_sel == psgt_pkg::REG_GAP_LIMIT)) begin
			gap_limit <= pwdata[15:0];
		end
	end

	// Read mux; unmapped addresses read as zero.
	always_comb begin
		unique case (reg_sel)
			psgt_pkg::REG_GAP_LIMIT: prdata = {16'b0, gap_limit};
			default:                 prdata = 32'b0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/psgt_table.sv
`default_nettype none

module psgt_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             upd_en,
	input  wire psgt_pkg::item_t  item_s1,
	input  wire logic [15:0]      gap_limit,
	output psgt_pkg::result_t     result_d
);

	logic        seen_q  [psgt_pkg::NUM_STREAMS];
	logic [15:0] last_q  [psgt_pkg::NUM_STREAMS];
	logic [31:0] rcv_q   [psgt_pkg::NUM_STREAMS];
	logic [31:0] lost_q  [psgt_pkg::NUM_STREAMS];
	logic [31:0] fsync_q [psgt_pkg::NUM_STREAMS];

	logic                           id_ok;
	logic [7:0]                     id_m1;
	logic [psgt_pkg::STREAM_IDX_W-1:0] idx;
	logic                           seen;
	logic [15:0]                    raw_gap;
	logic [15:0]                    gap_eff;
	logic                           is_fsync;
	logic [31:0]                    rcv_nx;
	logic [31:0]                    lost_nx;
	logic [31:0]                    fsync_nx;

	// Decode the stream id and look up its entry.
	assign id_ok = (item_s1.stream_id != 8'd0) && (item_s1.stream_id <= psgt_pkg::STREAM_ID_MAX);
	assign id_m1 = item_s1.stream_id - 8'd1;
	assign idx   = id_m1[psgt_pkg::STREAM_IDX_W-1:0];
	assign seen  = seen_q[idx];

	// Wrapping gap and false sync check; a first packet has no gap.
	assign raw_gap  = item_s1.sequence_number - last_q[idx] - 16'd1;
	assign gap_eff  = seen ? raw_gap : 16'd0;
	assign is_fsync = seen && (raw_gap >= gap_limit);

	// Counter values after this packet.
	assign rcv_nx   = is_fsync ? rcv_q[idx] : rcv_q[idx] + 32'd1;
	assign lost_nx  = is_fsync ? lost_q[idx] : lost_q[idx] + {16'b0, gap_eff};
	assign fsync_nx = is_fsync ? fsync_q[idx] + 32'd1 : fsync_q[idx];

	// Per-stream state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < psgt_pkg::NUM_STREAMS; k++) begin
				seen_q[k]  <= 1'b0;
				last_q[k]  <= 16'd0;
				rcv_q[k]   <= 32'd0;
				lost_q[k]  <= 32'd0;
				fsync_q[k] <= 32'd0;
			end
		end else if (upd_en && id_ok) begin
			seen_q[idx]  <= 1'b1;
			rcv_q[idx]   <= rcv_nx;
			lost_q[idx]  <= lost_nx;
			fsync_q[idx] <= fsync_nx;
			if (!is_fsync) begin
				last_q[idx] <= item_s1.sequence_number;
			end
		end
	end

	// Result beat; an ignored id reports all zeros.
	always_comb begin
		if (!id_ok) begin
			result_d = '0;
			result_d.outcome = psgt_pkg::OUTCOME_IGNORED;
		end else begin
			if (!seen) begin
				result_d.outcome = psgt_pkg::OUTCOME_FIRST;
			end else if (is_fsync) begin
				result_d.outcome = psgt_pkg::OUTCOME_FALSE_SYNC;
			end else begin
				result_d.outcome = psgt_pkg::OUTCOME_ACCEPTED;
			end
			result_d.gap              = gap_eff;
			result_d.received_total   = rcv_nx;
			result_d.lost_total       = lost_nx;
			result_d.false_sync_total = fsync_nx;
		end
	end

endmodule

`default_nettype wire
